// ===== rtl/ettf_pkg.sv =====
package ettf_pkg;

  localparam int ENTRIES   = 16;
  localparam int IDX_W     = 4;
  localparam int CNT_W     = 5;
  localparam int PIN_W     = 16;
  localparam int PAGE_W    = 8;
  localparam int CMD_W     = 3;
  localparam int STATUS_W  = 3;
  // feedback, fall, rise, clear, set
  localparam int ENTRY_W   = 5 * PIN_W;

  localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LEARN  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_COUNT  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_SETOUT = 3'd5;

  localparam logic [STATUS_W-1:0] ST_NOP       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DONE      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNCHANGED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EXISTS    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_SCAN, S_WRITE, S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic             load;     // capture the item, clear scan state
    logic             eval;     // evaluate the entry read last cycle
    logic             commit;   // apply the outcome
    logic [IDX_W-1:0] idx;      // memory read address
    logic             last;     // eval is on the final entry
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic             done;     // scan can stop early
  } dp_stat_t;

endpackage

// ===== rtl/ettf_if.sv =====
interface ettf_in_if (input logic clk);
  logic                              valid;
  logic                              ready;
  logic [ettf_pkg::CMD_W-1:0]        command;
  logic [ettf_pkg::PIN_W-1:0]        pin_value;
  logic [ettf_pkg::PIN_W-1:0]        next_value;
  logic [ettf_pkg::PAGE_W-1:0]       page;
  modport source (output valid, command, pin_value, next_value, page, input ready);
  modport sink (input valid, command, pin_value, next_value, page, output ready);
endinterface

interface ettf_out_if (input logic clk);
  logic                              valid;
  logic                              ready;
  logic [ettf_pkg::PIN_W-1:0]        output_value;
  logic [ettf_pkg::STATUS_W-1:0]     status;
  logic [ettf_pkg::CNT_W-1:0]        entry_count;
  modport source (output valid, output_value, status, entry_count, input ready);
  modport sink (input valid, output_value, status, entry_count, output ready);
endinterface

// ===== rtl/ettf_ram.sv =====
module ettf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/ettf_ctrl.sv =====
module ettf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ettf_pkg::dp_stat_t  stat,
  output ettf_pkg::dp_cmd_t   cmd
);
  ettf_pkg::state_t state, state_next;
  logic [ettf_pkg::IDX_W-1:0] idx, idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ettf_pkg::S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    cmd.idx    = idx;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ettf_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          idx_next   = '0;
          state_next = ettf_pkg::S_RD;
        end
      end
      ettf_pkg::S_RD: begin
        state_next = ettf_pkg::S_SCAN;
      end
      ettf_pkg::S_SCAN: begin
        // entry idx on read data; read idx+1 in parallel
        cmd.eval = 1'b1;
        cmd.last = (idx == ettf_pkg::IDX_W'(ettf_pkg::ENTRIES - 1));
        cmd.idx  = idx + 1'b1;
        if (cmd.last || stat.done) begin
          state_next = ettf_pkg::S_WRITE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ettf_pkg::S_WRITE: begin
        cmd.commit = 1'b1;
        state_next = ettf_pkg::S_OUT;
      end
      ettf_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = ettf_pkg::S_IDLE;
        end
      end
      default: state_next = ettf_pkg::S_IDLE;
    endcase
  end
endmodule

// ===== rtl/ettf_dp.sv =====
module ettf_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  ettf_pkg::dp_cmd_t             cmd,
  output ettf_pkg::dp_stat_t            stat,
  input  logic [ettf_pkg::CMD_W-1:0]    command,
  input  logic [ettf_pkg::PIN_W-1:0]    pin_value,
  input  logic [ettf_pkg::PIN_W-1:0]    next_value,
  input  logic [ettf_pkg::PAGE_W-1:0]   page,
  output logic [ettf_pkg::PIN_W-1:0]    output_value,
  output logic [ettf_pkg::STATUS_W-1:0] status,
  output logic [ettf_pkg::CNT_W-1:0]    entry_count
);
  logic [ettf_pkg::PAGE_W-1:0]  pg_tab [ettf_pkg::ENTRIES];
  logic [ettf_pkg::PIN_W-1:0]   prev_pins, cur_out;

  logic [ettf_pkg::CMD_W-1:0]   c_cmd;
  logic [ettf_pkg::PIN_W-1:0]   c_pins, c_next;
  logic [ettf_pkg::PAGE_W-1:0]  c_page;

  // scan results
  logic                         hit, empty_found, any_occ;
  logic [ettf_pkg::IDX_W-1:0]   hit_idx, empty_idx;
  logic [ettf_pkg::PIN_W-1:0]   hit_out;
  logic [ettf_pkg::CNT_W-1:0]   cnt;

  logic                         ram_we;
  logic [ettf_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
  logic [ettf_pkg::PIN_W-1:0]   e_fb, e_fall, e_rise, e_clr, e_set;
  logic [ettf_pkg::PIN_W-1:0]   fall, rise;
  logic [ettf_pkg::PAGE_W-1:0]  e_pg;
  logic [ettf_pkg::IDX_W-1:0]   eidx;
  logic                         occ, edges_eq, m_read, m_dup, m_rem;

  assign fall = prev_pins & ~c_pins;
  assign rise = c_pins & ~prev_pins;
  assign {e_fb, e_fall, e_rise, e_clr, e_set} = ram_rdata;

  // during eval the entry under test is the one before cmd.idx
  assign eidx     = cmd.idx - 1'b1;
  assign e_pg     = pg_tab[eidx];
  assign occ      = (e_pg != '0);
  assign edges_eq = (e_fall == fall) && (e_rise == rise);
  assign m_read   = occ && edges_eq && ((e_pg == 8'd1) || (e_fb == cur_out));
  assign m_dup    = m_read;
  assign m_rem    = occ && edges_eq && (e_fb == ((e_pg == 8'd1) ? c_pins : cur_out));

  always_comb begin
    stat.done = 1'b0;
    case (c_cmd)
      ettf_pkg::CMD_READ:   stat.done = (c_pins == prev_pins) || m_read;
      ettf_pkg::CMD_LEARN:  stat.done = (c_page == '0) || (c_pins == prev_pins) || m_dup;
      ettf_pkg::CMD_REMOVE: stat.done = m_rem;
      ettf_pkg::CMD_SETOUT: stat.done = 1'b1;
      default:              stat.done = 1'b0;
    endcase
    if (!cmd.eval) begin
      stat.done = 1'b0;
    end
  end

  // learn write data
  always_comb begin
    if (c_page > 8'd1) begin
      ram_wdata = {cur_out, fall, rise, cur_out & ~c_next, c_next & ~cur_out};
    end else begin
      ram_wdata = {c_pins, fall, rise, ~c_next, c_next};
    end
  end
  assign ram_we = cmd.commit && (c_cmd == ettf_pkg::CMD_LEARN) && (c_page != '0)
                  && (c_pins != prev_pins) && !hit && empty_found;

  ettf_ram #(.WIDTH(ettf_pkg::ENTRY_W), .DEPTH(ettf_pkg::ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (empty_idx),
    .wdata (ram_wdata),
    .raddr (cmd.idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_cmd  <= command;
      c_pins <= pin_value;
      c_next <= next_value;
      c_page <= page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pins   <= '0;
      cur_out     <= '0;
      hit         <= 1'b0;
      empty_found <= 1'b0;
      any_occ     <= 1'b0;
      hit_idx     <= '0;
      empty_idx   <= '0;
      hit_out     <= '0;
      cnt         <= '0;
      status      <= ettf_pkg::ST_NOP;
      entry_count <= '0;
      for (int k = 0; k < ettf_pkg::ENTRIES; k++) pg_tab[k] <= '0;
    end else begin
      if (cmd.load) begin
        hit         <= 1'b0;
        empty_found <= 1'b0;
        any_occ     <= 1'b0;
        cnt         <= '0;
      end
      if (cmd.eval) begin
        if (occ) begin
          any_occ <= 1'b1;
          cnt     <= cnt + 1'b1;
        end else if (!empty_found) begin
          empty_found <= 1'b1;
          empty_idx   <= eidx;
        end
        if (((c_cmd == ettf_pkg::CMD_REMOVE) ? m_rem : m_read) && !hit) begin
          hit     <= 1'b1;
          hit_idx <= eidx;
          hit_out <= (e_fb | e_set) & ~e_clr;
        end
      end
      if (cmd.commit) begin
        entry_count <= '0;
        status      <= ettf_pkg::ST_NOP;
        case (c_cmd)
          ettf_pkg::CMD_READ: begin
            if (c_pins == prev_pins) begin
              status <= ettf_pkg::ST_UNCHANGED;
            end else if (hit) begin
              status    <= ettf_pkg::ST_DONE;
              prev_pins <= c_pins;
              cur_out   <= hit_out;
            end else if (any_occ) begin
              status <= ettf_pkg::ST_NOTFOUND;
            end
          end
          ettf_pkg::CMD_LEARN: begin
            if (c_page != '0 && c_pins != prev_pins) begin
              if (hit) begin
                status <= ettf_pkg::ST_EXISTS;
              end else if (empty_found) begin
                status            <= ettf_pkg::ST_DONE;
                pg_tab[empty_idx] <= c_page;
              end else begin
                status <= ettf_pkg::ST_FULL;
              end
            end
          end
          ettf_pkg::CMD_REMOVE: begin
            if (hit) begin
              status          <= ettf_pkg::ST_DONE;
              pg_tab[hit_idx] <= '0;
            end else begin
              status <= ettf_pkg::ST_NOTFOUND;
            end
          end
          ettf_pkg::CMD_CLEAR: begin
            if (any_occ) begin
              status <= ettf_pkg::ST_DONE;
            end
            for (int k = 0; k < ettf_pkg::ENTRIES; k++) pg_tab[k] <= '0;
          end
          ettf_pkg::CMD_COUNT: begin
            status      <= ettf_pkg::ST_DONE;
            entry_count <= cnt;
          end
          ettf_pkg::CMD_SETOUT: begin
            status  <= ettf_pkg::ST_DONE;
            cur_out <= c_next;
          end
          default: status <= ettf_pkg::ST_NOP;
        endcase
      end
    end
  end

  assign output_value = cur_out;
endmodule

// ===== rtl/edge_transition_table_fsm_top.sv =====
// Scan: one memory read per table entry, stopping at the first decisive entry.
// Flow: one item at a time, with up to 16 entries scanned through the single
// read port of the entry RAM.
// Reset: synchronous rst empties all entries and zeroes pins and output;
// entry contents stay undefined until learned.
module edge_transition_table_fsm_top (
  input  logic      clk,
  input  logic      rst,
  ettf_in_if.sink   in_ch,
  ettf_out_if.source out_ch
);
  ettf_pkg::dp_cmd_t  cmd;
  ettf_pkg::dp_stat_t stat;

  ettf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ettf_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .command      (in_ch.command),
    .pin_value    (in_ch.pin_value),
    .next_value   (in_ch.next_value),
    .page         (in_ch.page),
    .output_value (out_ch.output_value),
    .status       (out_ch.status),
    .entry_count  (out_ch.entry_count)
  );
endmodule

// ===== tb/edge_transition_table_fsm_top_test.sv =====
`timescale 1ns / 100ps

module edge_transition_table_fsm_top_test;

  typedef struct {
    logic [ettf_pkg::CMD_W-1:0]    cmd;
    logic [ettf_pkg::PIN_W-1:0]    pins;
    logic [ettf_pkg::PIN_W-1:0]    nxt;
    logic [ettf_pkg::PAGE_W-1:0]   pg;
    bit                            drain;   // wait for all results before offering
  } op_t;

  typedef struct {
    logic [ettf_pkg::PIN_W-1:0]    out_word;
    logic [ettf_pkg::STATUS_W-1:0] status;
    logic [ettf_pkg::CNT_W-1:0]    count;
  } res_t;

  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG    = 5000;

  logic clk = 0;
  logic rst = 1;
  always #4 clk = ~clk;

  ettf_in_if  in_ch (clk);
  ettf_out_if out_ch (clk);

  edge_transition_table_fsm_top dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  // shadow of the transition table
  logic [ettf_pkg::PAGE_W-1:0] tbl_page [ettf_pkg::ENTRIES];
  logic [ettf_pkg::PIN_W-1:0]  tbl_fb [ettf_pkg::ENTRIES], tbl_fall [ettf_pkg::ENTRIES];
  logic [ettf_pkg::PIN_W-1:0]  tbl_rise [ettf_pkg::ENTRIES];
  logic [ettf_pkg::PIN_W-1:0]  tbl_clr [ettf_pkg::ENTRIES], tbl_set [ettf_pkg::ENTRIES];
  logic [ettf_pkg::PIN_W-1:0]  last_pins, out_word;

  op_t  op_q [$];
  res_t result_q [$];
  op_t  cur_op;
  int   total_ops, n_sent, n_recv, n_err, send_gap, recv_gap, hold_left, idle_cycles;
  bit   hold_done;
  int   status_seen [8];
  logic tail;

  function automatic res_t step_table(op_t op);
    res_t r;
    logic [ettf_pkg::PIN_W-1:0] fall, rise, want;
    logic hit, dup;
    fall = last_pins & ~op.pins;
    rise = op.pins & ~last_pins;
    r.status = ettf_pkg::ST_NOP;
    r.count = '0;
    case (op.cmd)
      ettf_pkg::CMD_READ: begin
        if (op.pins == last_pins) r.status = ettf_pkg::ST_UNCHANGED;
        else begin
          for (int k = 0; k < ettf_pkg::ENTRIES; k++) begin
            if (tbl_page[k] == 0) continue;
            hit = tbl_fall[k] == fall && tbl_rise[k] == rise;
            if (tbl_page[k] != 1) hit = hit && tbl_fb[k] == out_word;
            if (hit) begin
              r.status = ettf_pkg::ST_DONE;
              last_pins = op.pins;
              out_word = (tbl_fb[k] | tbl_set[k]) & ~tbl_clr[k];
              break;
            end
            r.status = ettf_pkg::ST_NOTFOUND;
          end
        end
      end
      ettf_pkg::CMD_LEARN: begin
        if (op.pg != 0 && op.pins != last_pins) begin
          dup = 1'b0;
          for (int k = 0; k < ettf_pkg::ENTRIES; k++)
            if (tbl_page[k] != 0 && tbl_fall[k] == fall && tbl_rise[k] == rise &&
                (tbl_fb[k] == out_word || tbl_page[k] == 1)) dup = 1'b1;
          if (dup) r.status = ettf_pkg::ST_EXISTS;
          else begin
            r.status = ettf_pkg::ST_FULL;
            for (int k = 0; k < ettf_pkg::ENTRIES; k++) begin
              if (tbl_page[k] != 0) continue;
              tbl_page[k] = op.pg;
              tbl_fall[k] = fall;
              tbl_rise[k] = rise;
              if (op.pg > 1) begin
                tbl_fb[k] = out_word;
                tbl_clr[k] = out_word & ~op.nxt;
                tbl_set[k] = op.nxt & ~out_word;
              end else begin
                tbl_fb[k] = op.pins;
                tbl_clr[k] = ~op.nxt;
                tbl_set[k] = op.nxt;
              end
              r.status = ettf_pkg::ST_DONE;
              break;
            end
          end
        end
      end
      ettf_pkg::CMD_REMOVE: begin
        r.status = ettf_pkg::ST_NOTFOUND;
        for (int k = 0; k < ettf_pkg::ENTRIES; k++) begin
          if (tbl_page[k] == 0) continue;
          want = (tbl_page[k] == 1) ? op.pins : out_word;
          if (tbl_fb[k] == want && tbl_fall[k] == fall && tbl_rise[k] == rise) begin
            tbl_page[k] = '0;
            r.status = ettf_pkg::ST_DONE;
            break;
          end
        end
      end
      ettf_pkg::CMD_CLEAR: begin
        for (int k = 0; k < ettf_pkg::ENTRIES; k++)
          if (tbl_page[k] != 0) begin
            tbl_page[k] = '0;
            r.status = ettf_pkg::ST_DONE;
          end
      end
      ettf_pkg::CMD_COUNT: begin
        for (int k = 0; k < ettf_pkg::ENTRIES; k++) if (tbl_page[k] != 0) r.count++;
        r.status = ettf_pkg::ST_DONE;
      end
      ettf_pkg::CMD_SETOUT: begin
        out_word = op.nxt;
        r.status = ettf_pkg::ST_DONE;
      end
      default: ;
    endcase
    r.out_word = out_word;
    return r;
  endfunction

  task automatic push_op(logic [ettf_pkg::CMD_W-1:0] cmd, logic [ettf_pkg::PIN_W-1:0] pins,
                         logic [ettf_pkg::PIN_W-1:0] nxt, logic [ettf_pkg::PAGE_W-1:0] pg,
                         bit drain = 1'b0);
    op_t op;
    op.cmd = cmd; op.pins = pins; op.nxt = nxt; op.pg = pg; op.drain = drain;
    op_q.push_back(op);
  endtask

  task automatic gen_pool_phase(int n);
    logic [ettf_pkg::PIN_W-1:0] pool [4];
    int sel;
    logic [ettf_pkg::PAGE_W-1:0] pg;
    foreach (pool[i]) pool[i] = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      pg = ($urandom_range(0, 1)) ? 8'd1 : 8'($urandom_range(2, 255));
      if (sel < 45)      push_op(ettf_pkg::CMD_READ, pool[2'($urandom)], '0, '0);
      else if (sel < 75) push_op(ettf_pkg::CMD_LEARN, pool[2'($urandom)],
                                 $urandom_range(0, 1) ? pool[2'($urandom)] : 16'($urandom), pg);
      else if (sel < 84) push_op(ettf_pkg::CMD_REMOVE, pool[2'($urandom)], '0, '0);
      else if (sel < 90) push_op(ettf_pkg::CMD_SETOUT, '0, pool[2'($urandom)], '0);
      else if (sel < 95) push_op(ettf_pkg::CMD_COUNT, 16'($urandom), 16'($urandom),
                                 8'($urandom));
      else if (sel < 97) push_op(ettf_pkg::CMD_CLEAR, 16'($urandom), 16'($urandom),
                                 8'($urandom));
      else push_op(3'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 0;
      in_ch.command <= '0;
      in_ch.pin_value <= '0;
      in_ch.next_value <= '0;
      in_ch.page <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        result_q.push_back(step_table(cur_op));
        n_sent <= n_sent + 1;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_ch.valid <= 0;
        end else if (op_q.size() != 0 && !(op_q[0].drain && result_q.size() != 0)) begin
          if (!tail && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(0, 7);
            in_ch.valid <= 0;
          end else begin
            cur_op = op_q.pop_front();
            in_ch.valid <= 1;
            in_ch.command <= cur_op.cmd;
            in_ch.pin_value <= cur_op.pins;
            in_ch.next_value <= cur_op.nxt;
            in_ch.page <= cur_op.pg;
          end
        end else in_ch.valid <= 0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 0;
      recv_gap <= 0;
      hold_left <= 0;
      hold_done <= 0;
    end else if (!hold_done && n_recv == 200) begin
      hold_done <= 1;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= (hold_left == 1);
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ch.ready <= (recv_gap == 1);
    end else if (!tail && $urandom_range(0, 9) == 0) begin
      recv_gap <= $urandom_range(1, 8);
      out_ch.ready <= 0;
    end else out_ch.ready <= 1;
  end

  // result checker
  always @(posedge clk) begin
    res_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      n_recv <= n_recv + 1;
      status_seen[out_ch.status] <= status_seen[out_ch.status] + 1;
      if (result_q.size() == 0) begin
        $display("%0t: result with none expected: out %h status %0d count %0d", $time,
                 out_ch.output_value, out_ch.status, out_ch.entry_count);
        n_err <= n_err + 1;
      end else begin
        want = result_q.pop_front();
        if (out_ch.output_value !== want.out_word || out_ch.status !== want.status ||
            out_ch.entry_count !== want.count) begin
          $display("%0t: mismatch: expected out %h status %0d count %0d, got %h %0d %0d",
                   $time, want.out_word, want.status, want.count,
                   out_ch.output_value, out_ch.status, out_ch.entry_count);
          n_err <= n_err + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    tail <= (total_ops - n_sent) < 150;
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog: %0d items sent, %0d results", n_sent, n_recv);
      $display("edge_transition_table_fsm_top_test: errors");
      $finish;
    end
  end

  initial begin
    foreach (tbl_page[k]) tbl_page[k] = '0;
    foreach (status_seen[k]) status_seen[k] = 0;
    last_pins = '0; out_word = '0;
    n_sent = 0; n_recv = 0; n_err = 0; send_gap = 0; idle_cycles = 0;
    tail = 0; total_ops = 0;

    // directed
    push_op(ettf_pkg::CMD_SETOUT, 16'h0000, 16'hFFFF, 8'd0);
    push_op(ettf_pkg::CMD_SETOUT, 16'h0000, 16'h0000, 8'd0);
    push_op(ettf_pkg::CMD_READ, 16'h0000, 16'h0000, 8'd0);    // pins unchanged
    push_op(ettf_pkg::CMD_READ, 16'hFFFF, 16'h0000, 8'd0);    // empty table
    push_op(ettf_pkg::CMD_LEARN, 16'h00FF, 16'hA5A5, 8'd0);   // page zero
    push_op(ettf_pkg::CMD_LEARN, 16'h0000, 16'hA5A5, 8'd1);   // pins unchanged
    push_op(ettf_pkg::CMD_LEARN, 16'h00FF, 16'hA5A5, 8'd1);
    push_op(ettf_pkg::CMD_LEARN, 16'h00FF, 16'h1234, 8'd1);   // duplicate
    push_op(ettf_pkg::CMD_LEARN, 16'hFF00, 16'hFFFF, 8'hFF);
    push_op(ettf_pkg::CMD_COUNT, 16'h0000, 16'h0000, 8'd0);
    push_op(ettf_pkg::CMD_READ, 16'h0F0F, 16'h0000, 8'd0);    // no match
    push_op(ettf_pkg::CMD_READ, 16'h00FF, 16'h0000, 8'd0);    // logic hit
    push_op(ettf_pkg::CMD_LEARN, 16'h0000, 16'h5A5A, 8'd2);
    push_op(ettf_pkg::CMD_READ, 16'h0000, 16'h0000, 8'd0);    // sequence hit
    push_op(ettf_pkg::CMD_REMOVE, 16'h1111, 16'h0000, 8'd0);  // no match
    push_op(ettf_pkg::CMD_SETOUT, 16'h0000, 16'h0000, 8'd0);
    push_op(ettf_pkg::CMD_REMOVE, 16'hFF00, 16'h0000, 8'd0);
    push_op(3'd6, 16'hFFFF, 16'hFFFF, 8'hFF);
    push_op(3'd7, 16'hFFFF, 16'hFFFF, 8'hFF);
    push_op(ettf_pkg::CMD_CLEAR, 16'h0000, 16'h0000, 8'd0);
    push_op(ettf_pkg::CMD_CLEAR, 16'h0000, 16'h0000, 8'd0);   // already empty
    push_op(ettf_pkg::CMD_COUNT, 16'h0000, 16'h0000, 8'd0, 1'b1);

    // random: filling bursts, small pin pools, noise
    while (op_q.size() < 1500) begin
      case ($urandom_range(0, 4))
        0: begin
          for (int i = 0; i < 18; i++)
            push_op(ettf_pkg::CMD_LEARN, 16'($urandom), 16'($urandom),
                    8'($urandom_range(1, 255)));
          push_op(ettf_pkg::CMD_COUNT, '0, '0, '0);
          push_op(ettf_pkg::CMD_CLEAR, '0, '0, '0, $urandom_range(0, 3) == 0);
        end
        1: for (int i = 0; i < 10; i++)
             push_op(3'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
        default: gen_pool_phase($urandom_range(20, 60));
      endcase
    end
    total_ops = op_q.size();

    repeat (10) @(posedge clk);
    rst <= 0;
    wait (op_q.size() == 0 && n_sent == total_ops && result_q.size() == 0);
    repeat (40) @(posedge clk);
    $display("%0d items, %0d results; status counts nop %0d done %0d notfound %0d",
             n_sent, n_recv, status_seen[ettf_pkg::ST_NOP], status_seen[ettf_pkg::ST_DONE],
             status_seen[ettf_pkg::ST_NOTFOUND]);
    $display("unchanged %0d exists %0d full %0d", status_seen[ettf_pkg::ST_UNCHANGED],
             status_seen[ettf_pkg::ST_EXISTS], status_seen[ettf_pkg::ST_FULL]);
    if (n_err == 0 && result_q.size() == 0)
      $display("edge_transition_table_fsm_top_test: clean");
    else
      $display("edge_transition_table_fsm_top_test: errors");
    $finish;
  end

endmodule
